// ===== sv/gbs_pkg.sv =====
// shared types and constants of the greedy box suppression core
`default_nettype none

package gbs_pkg;

   // stream payload layout
   localparam int unsigned REQ_DATA_W       = 64;
   localparam int unsigned RSP_DATA_W       = 24;
   localparam int unsigned RSP_KEEP_BIT     = 0;
   localparam int unsigned RSP_NUMBER_LSB   = 1;
   localparam int unsigned RSP_NUMBER_MSB   = 16;
   localparam int unsigned RSP_OVERFLOW_BIT = 17;

   // iou threshold after reset, q0.16
   localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

   // one box as it travels down the chain of cells
   typedef struct packed {
      logic               valid;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [15:0]        width;
      logic [15:0]        height;
      logic [31:0]        area;
      logic               last;
      logic [15:0]        number;
      logic               suppressed;
      logic               stored;
   } gbs_item_type;

endpackage

`default_nettype wire

// ===== sv/gbs_cell.sv =====
// one cell of the suppression chain: holds one kept box, tests passing boxes
`default_nettype none

module gbs_cell import gbs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic [15:0]  threshold,
   input  wire gbs_item_type item_in,
   output gbs_item_type      item_out
);

   // stored box
   logic               occupied_ff, occupied_in;
   logic signed [15:0] kept_left_ff;
   logic signed [15:0] kept_top_ff;
   logic [15:0]        kept_width_ff;
   logic [15:0]        kept_height_ff;
   logic [31:0]        kept_area_ff;

   // first half: intersection and union
   gbs_item_type s1_item_ff, s1_item_in;
   logic [31:0]  s1_inter_ff, s1_inter_in;
   logic [32:0]  s1_union_ff, s1_union_in;
   logic         s1_check_ff, s1_check_in;

   // second half: threshold test
   gbs_item_type out_ff, out_in;

   logic signed [17:0] new_right, kept_right, hi_x, lo_x, ext_x;
   logic signed [17:0] new_bottom, kept_bottom, hi_y, lo_y, ext_y;
   logic [15:0]        overlap_x, overlap_y;
   logic               take_slot;
   logic [48:0]        scaled_union, scaled_inter;

   always_comb begin
      new_right   = 18'(item_in.left) + signed'({2'b00, item_in.width});
      kept_right  = 18'(kept_left_ff) + signed'({2'b00, kept_width_ff});
      new_bottom  = 18'(item_in.top) + signed'({2'b00, item_in.height});
      kept_bottom = 18'(kept_top_ff) + signed'({2'b00, kept_height_ff});

      lo_x = (item_in.left > kept_left_ff) ? 18'(item_in.left) : 18'(kept_left_ff);
      hi_x = (new_right < kept_right) ? new_right : kept_right;
      lo_y = (item_in.top > kept_top_ff) ? 18'(item_in.top) : 18'(kept_top_ff);
      hi_y = (new_bottom < kept_bottom) ? new_bottom : kept_bottom;
      ext_x = hi_x - lo_x;
      ext_y = hi_y - lo_y;
      // extent never exceeds the narrower box, so 16 bits hold it
      overlap_x = (hi_x > lo_x) ? ext_x[15:0] : 16'd0;
      overlap_y = (hi_y > lo_y) ? ext_y[15:0] : 16'd0;

      s1_inter_in = 32'(overlap_x) * 32'(overlap_y);
      s1_union_in = {1'b0, item_in.area} + {1'b0, kept_area_ff} - {1'b0, s1_inter_in};
      s1_check_in = occupied_ff && !item_in.suppressed;

      // first free cell takes a surviving box
      take_slot = item_in.valid && !occupied_ff && !item_in.suppressed && !item_in.stored;
      s1_item_in        = item_in;
      s1_item_in.stored = item_in.stored || take_slot;

      occupied_in = occupied_ff;
      if (item_in.valid && item_in.last) begin
         occupied_in = 1'b0;
      end else if (take_slot) begin
         occupied_in = 1'b1;
      end

      scaled_union = 49'(threshold) * 49'(s1_union_ff);
      scaled_inter = {1'b0, s1_inter_ff, 16'd0};
      out_in            = s1_item_ff;
      out_in.suppressed = s1_item_ff.suppressed || (s1_check_ff && scaled_inter > scaled_union);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff      <= 1'b0;
         s1_item_ff.valid <= 1'b0;
         out_ff.valid     <= 1'b0;
      end else if (advance) begin
         occupied_ff <= occupied_in;
         s1_item_ff  <= s1_item_in;
         out_ff      <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inter_ff <= s1_inter_in;
         s1_union_ff <= s1_union_in;
         s1_check_ff <= s1_check_in;
         if (take_slot && !item_in.last) begin
            kept_left_ff   <= item_in.left;
            kept_top_ff    <= item_in.top;
            kept_width_ff  <= item_in.width;
            kept_height_ff <= item_in.height;
            kept_area_ff   <= item_in.area;
         end
      end
   end

   assign item_out = out_ff;

endmodule

`default_nettype wire

// ===== sv/greedy_box_suppression_core.sv =====
// top level of the greedy box suppression core
`default_nettype none

// Greedy non-maximum suppression over boxes that arrive sorted by descending
// score. Each req item is one box (left, top, width, height in Q12.4 pixels)
// and tlast marks the last box of a frame. Boxes walk down a row of MAX_KEPT
// cells; each cell holds one kept box and tests every passing box against it
// (intersection * 65536 > threshold * union suppresses). A box that reaches
// the first free cell unsuppressed is stored there; one that finds every cell
// full comes out kept with store_overflow set. A tlast box empties each cell
// as it passes, so the next frame starts with an empty store. One rsp item
// comes out per box, in order. The chain takes a new item every cycle while
// rsp_tready is high, so the sustained rate is one item per clock; from req
// to rsp each box passes a chain of registers (one entry stage, then two stages
// per cell: overlap multiply, then threshold multiply). A stall on rsp_tready
// holds the whole chain. csr_wr_data is the iou threshold (unsigned Q0.16);
// write it only while no box is in flight.
module greedy_box_suppression_core import gbs_pkg::*; #(
   parameter int unsigned MAX_KEPT = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // box_left [15:0], box_top [31:16], box_width [47:32], box_height [63:48]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,   // last_box
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // keep [0], box_number [16:1], store_overflow [17], zero fill [23:18]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,   // frame_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data
);

   logic         advance;
   logic [15:0]  threshold_ff;
   logic [15:0]  counter_ff, counter_in;
   gbs_item_type entry_ff, entry_in;
   gbs_item_type chain [0:MAX_KEPT];
   gbs_item_type tail;
   logic         accept;

   // whole chain moves unless the result at its end is held
   assign advance    = !chain[MAX_KEPT].valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // box number within the frame, back to zero after the last box
   always_comb begin
      counter_in = counter_ff;
      if (accept) begin
         counter_in = req_tlast ? 16'd0 : counter_ff + 16'd1;
      end
   end

   // entry stage: unpack the item and form its area once
   always_comb begin
      entry_in.valid      = req_tvalid;
      entry_in.left       = signed'(req_tdata[15:0]);
      entry_in.top        = signed'(req_tdata[31:16]);
      entry_in.width      = req_tdata[47:32];
      entry_in.height     = req_tdata[63:48];
      entry_in.area       = 32'(req_tdata[47:32]) * 32'(req_tdata[63:48]);
      entry_in.last       = req_tlast;
      entry_in.number     = counter_ff;
      entry_in.suppressed = 1'b0;
      entry_in.stored     = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff     <= 16'd0;
         entry_ff.valid <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         if (advance) begin
            entry_ff <= entry_in;
         end
      end
   end

   assign chain[0] = entry_ff;

   // one cell per store slot, each handing the box on to the next
   for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
      gbs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .threshold (threshold_ff),
         .item_in   (chain[g]),
         .item_out  (chain[g+1])
      );
   end

   // the last cell's output register is the result register
   assign tail       = chain[MAX_KEPT];
   assign rsp_tvalid = tail.valid;
   assign rsp_tlast  = tail.last;
   always_comb begin
      rsp_tdata                                 = '0;
      rsp_tdata[RSP_KEEP_BIT]                   = !tail.suppressed;
      rsp_tdata[RSP_NUMBER_MSB:RSP_NUMBER_LSB]  = tail.number;
      // kept but no free cell was found on the way
      rsp_tdata[RSP_OVERFLOW_BIT]               = !tail.suppressed && !tail.stored;
   end

endmodule

`default_nettype wire

// ===== sv/gbs_checker.sv =====
// port checker for the greedy box suppression core and its bind
`default_nettype none

module gbs_checker import gbs_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  req_tlast,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic                  csr_wr_en,
   input wire logic [15:0]           csr_wr_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // chain only stalls on a waiting result
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no result waiting");

   // nothing in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

   // a suppressed box never reports overflow
   a_overflow_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_KEEP_BIT] |-> !rsp_tdata[RSP_OVERFLOW_BIT])
      else $error("overflow flagged on a suppressed box");

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (.*);

`default_nettype wire

// ===== tb/sv/gbs_outcome_checker.sv =====
// outcome checker: predicts keep, box number and overflow per box and compares rsp items
module gbs_outcome_checker import gbs_pkg::*; #(
   parameter int unsigned MAX_KEPT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   output int unsigned           error_count,
   output int unsigned           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [15:0]        width;
      logic [15:0]        height;
   } box_type;

   typedef struct {
      logic        keep;
      logic [15:0] number;
      logic        overflow;
      logic        frame_end;
   } verdict_type;

   logic [15:0] threshold;
   box_type     kept [MAX_KEPT];
   logic [31:0] kept_area [MAX_KEPT];
   int unsigned kept_count;
   logic [15:0] box_counter;
   verdict_type expected_verdicts [$];
   int unsigned mismatches = 0;

   assign error_count = mismatches;

   // overlap length of two spans on one axis, zero when they only touch or miss
   function automatic logic [63:0] span_overlap(input logic signed [15:0] a_start,
                                                input logic [15:0] a_len,
                                                input logic signed [15:0] b_start,
                                                input logic [15:0] b_len);
      int a0, a1, b0, b1, lo, hi;
      a0 = a_start;
      b0 = b_start;
      a1 = a0 + int'(a_len);
      b1 = b0 + int'(b_len);
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      return (hi > lo) ? 64'(hi - lo) : 64'd0;
   endfunction

   // greedy suppression of one box against the kept store, updates the store
   function automatic verdict_type judge_box(input box_type nb, input logic last);
      verdict_type v;
      logic [63:0] area;
      logic [63:0] inter;
      logic [63:0] uni;
      logic        suppressed;
      suppressed = 1'b0;
      area = 64'(nb.width) * 64'(nb.height);
      for (int i = 0; i < kept_count; i++) begin
         inter = span_overlap(nb.left, nb.width, kept[i].left, kept[i].width)
               * span_overlap(nb.top, nb.height, kept[i].top, kept[i].height);
         uni = area + 64'(kept_area[i]) - inter;
         if ((inter << 16) > 64'(threshold) * uni)
            suppressed = 1'b1;
      end
      v.keep = !suppressed;
      v.overflow = 1'b0;
      if (!suppressed) begin
         if (kept_count < MAX_KEPT) begin
            kept[kept_count] = nb;
            kept_area[kept_count] = area[31:0];
            kept_count++;
         end else begin
            v.overflow = 1'b1;
         end
      end
      v.number = box_counter;
      v.frame_end = last;
      box_counter = box_counter + 16'd1;
      if (last) begin
         kept_count = 0;
         box_counter = '0;
      end
      return v;
   endfunction

   task automatic flag_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] seen);
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      box_type     arriving;
      verdict_type want;
      verdict_type seen;
      if (reset) begin
         threshold = THRESHOLD_RESET;
         kept_count = 0;
         box_counter = '0;
         expected_verdicts.delete();
      end else begin
         if (csr_wr_en)
            threshold = csr_wr_data;
         if (req_tvalid && req_tready) begin
            arriving.left   = req_tdata[15:0];
            arriving.top    = req_tdata[31:16];
            arriving.width  = req_tdata[47:32];
            arriving.height = req_tdata[63:48];
            expected_verdicts.insert(expected_verdicts.size(),
                                     judge_box(arriving, req_tlast));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.keep      = rsp_tdata[RSP_KEEP_BIT];
            seen.number    = rsp_tdata[RSP_NUMBER_MSB:RSP_NUMBER_LSB];
            seen.overflow  = rsp_tdata[RSP_OVERFLOW_BIT];
            seen.frame_end = rsp_tlast;
            if (expected_verdicts.size() == 0) begin
               $display("%0t ns: unexpected rsp item, expected nothing, got tdata %h tlast %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (seen.keep !== want.keep)
                  flag_mismatch("keep", want.keep, seen.keep);
               if (seen.number !== want.number)
                  flag_mismatch("box_number", want.number, seen.number);
               if (seen.overflow !== want.overflow)
                  flag_mismatch("store_overflow", want.overflow, seen.overflow);
               if (seen.frame_end !== want.frame_end)
                  flag_mismatch("frame_end", want.frame_end, seen.frame_end);
            end
         end
      end
      pending_count <= expected_verdicts.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: drives boxes and thresholds into the suppression core and reports the verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gbs_pkg::*;

   localparam int unsigned KEPT_DEPTH = 64;
   // one entry stage plus two stages per cell
   localparam int unsigned CHAIN_LATENCY = 1 + 2 * KEPT_DEPTH;
   // long enough to back the whole chain up into the input
   localparam int unsigned LONG_HOLD_CYCLES = 3 * CHAIN_LATENCY;
   localparam int unsigned PHASE_BOXES = 140;

   // req tdata layout, lowest field last in the declaration
   typedef struct packed {
      logic [15:0]        height;
      logic [15:0]        width;
      logic signed [15:0] top;
      logic signed [15:0] left;
   } box_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_SHUT} sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   // box_left [15:0], box_top [31:16], box_width [47:32], box_height [63:48]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;   // last_box
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // keep [0], box_number [16:1], store_overflow [17], zero fill [23:18]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;          // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [15:0]           csr_wr_data = '0;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned burst_left = 0;
   int unsigned boxes_sent = 0;
   // set by the stimulus, taken and cleared by the rsp sink
   bit          long_hold_wanted = 1'b0;

   always #2 clock = ~clock;

   greedy_box_suppression_core #(.MAX_KEPT(KEPT_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gbs_outcome_checker #(.MAX_KEPT(KEPT_DEPTH)) outcome_check (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // single reset pulse at the start of the run
   initial begin : reset_gen
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the block hangs
   initial begin : watchdog
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // rsp sink: open runs, choppy runs and short shut runs, plus an occasional long hold
   initial begin : rsp_sink
      int unsigned run_len;
      forever begin
         if (long_hold_wanted) begin
            // hold rsp off while the sender keeps offering, chain fills and req stalls
            long_hold_wanted = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            run_len = $urandom_range(1, 40);
            case (sink_mode_type'($urandom_range(0, 2)))
               SINK_OPEN: begin
                  rsp_tready <= 1'b1;
                  repeat (run_len) @(posedge clock);
               end
               SINK_CHOPPY: begin
                  repeat (run_len) begin
                     rsp_tready <= ($urandom_range(0, 1) == 1);
                     @(posedge clock);
                  end
               end
               default: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            endcase
         end
      end
   end

   function automatic box_type make_box(input int x, input int y, input int w, input int h);
      box_type b;
      b.left   = x[15:0];
      b.top    = y[15:0];
      b.width  = w[15:0];
      b.height = h[15:0];
      return b;
   endfunction

   // symmetric random offset in -span..span
   function automatic logic signed [15:0] jitter(input int unsigned span);
      int offset;
      offset = int'($urandom_range(0, 2 * span)) - int'(span);
      return offset[15:0];
   endfunction

   // offer one box; bursts of random length with random gaps in between
   task automatic offer_box(input box_type b, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      boxes_sent++;
   endtask

   // stop offering and wait until every box in flight has come back
   task automatic drain_chain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // boxes around a few centers with similar sizes, so overlaps land near the threshold
   task automatic send_cluster_frame();
      int unsigned        length;
      int unsigned        n_centers;
      int unsigned        c;
      logic signed [15:0] cx [3];
      logic signed [15:0] cy [3];
      logic [15:0]        base [3];
      box_type            b;
      length = $urandom_range(1, 24);
      n_centers = $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) begin
         cx[k] = jitter(4000);
         cy[k] = jitter(4000);
         base[k] = 16'($urandom_range(96, 640));
      end
      for (int i = 0; i < length; i++) begin
         c = $urandom_range(0, n_centers - 1);
         b.left   = cx[c] + jitter(64);
         b.top    = cy[c] + jitter(64);
         b.width  = base[c] + jitter(48);
         b.height = base[c] + jitter(48);
         // now and then an empty box
         if ($urandom_range(0, 15) == 0)
            b.width = '0;
         else if ($urandom_range(0, 15) == 0)
            b.height = '0;
         offer_box(b, i == length - 1);
      end
   endtask

   // short frames of fully random fields
   task automatic send_noise_frame();
      int unsigned length;
      length = $urandom_range(1, 6);
      for (int i = 0; i < length; i++)
         offer_box(box_type'({$urandom, $urandom}), i == length - 1);
   endtask

   // disjoint boxes on a grid, more than the store holds; some repeated right away
   task automatic send_grid_frame();
      int unsigned distinct;
      int          gx, gy;
      bit          twin;
      box_type     b;
      distinct = KEPT_DEPTH + $urandom_range(1, 8);
      for (int u = 0; u < distinct; u++) begin
         gx = -4096 + 512 * (u % 12) + int'($urandom_range(0, 63));
         gy = -4096 + 512 * (u / 12) + int'($urandom_range(0, 63));
         b = make_box(gx, gy, $urandom_range(16, 448), $urandom_range(16, 448));
         twin = ($urandom_range(0, 5) == 0);
         offer_box(b, (u == distinct - 1) && !twin);
         // a repeat is suppressed by its twin, unless the twin overflowed the store
         if (twin)
            offer_box(b, u == distinct - 1);
      end
   endtask

   // one threshold setting, written while idle, then well-formed frames and noise
   task automatic run_phase(input logic [15:0] threshold, input bit with_hold);
      int unsigned goal;
      drain_chain();
      write_threshold(threshold);
      if (with_hold)
         long_hold_wanted = 1'b1;
      goal = boxes_sent + PHASE_BOXES;
      send_grid_frame();
      while (boxes_sent < goal) begin
         if ($urandom_range(0, 3) == 0)
            send_noise_frame();
         else
            send_cluster_frame();
      end
   endtask

   initial begin : stimulus
      do @(posedge clock); while (reset);

      // directed frames at the reset threshold
      offer_box(make_box(0, 0, 0, 0), 1'b0);            // empty box, zero area, kept
      offer_box(make_box(0, 0, 0, 0), 1'b0);            // empty against empty, zero union
      offer_box(make_box(-32768, -32768, 65535, 65535), 1'b0); // widest box, lowest corner
      offer_box(make_box(-32768, -32768, 65535, 65535), 1'b0); // exact repeat, suppressed
      offer_box(make_box(32767, 32767, 65535, 65535), 1'b0);   // meets the big box at a corner
      offer_box(make_box(100, 100, 16, 16), 1'b0);      // small box inside the big one
      offer_box(make_box(104, 100, 16, 16), 1'b0);      // heavy overlap, suppressed
      offer_box(make_box(116, 100, 16, 16), 1'b0);      // shares only an edge, kept
      offer_box(make_box(100, 100, 16, 0), 1'b0);       // zero height on top of a kept box
      offer_box(make_box(-1, -1, 1, 1), 1'b1);          // end of frame clears the store
      offer_box(make_box(100, 100, 16, 16), 1'b0);      // same box again, fresh frame
      offer_box(make_box(101, 100, 16, 16), 1'b0);      // one step over, suppressed
      offer_box(make_box(-32768, 32767, 65535, 1), 1'b1);
      offer_box(make_box(32767, -32768, 1, 65535), 1'b1); // frame of a single box

      // threshold settings: suppress on any overlap, almost never, half, random, back to reset value
      run_phase(16'd0, 1'b0);
      run_phase(16'hFFFF, 1'b1);
      run_phase(16'h8000, 1'b0);
      run_phase(16'($urandom_range(1, 65534)), 1'b0);
      run_phase(THRESHOLD_RESET, 1'b0);

      drain_chain();
      repeat (2 * CHAIN_LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
